FILE: rtl/lwe_pkg.sv
// ----------------------------------------------------------------------------
// lwe_pkg
// Shared types, character codes and the Base64 alphabet for the line-wrapped
// encoder.
// ----------------------------------------------------------------------------
package lwe_pkg;

    // Default line length in characters
    localparam int LINE_CHARS_DEF = 76;

    // Character codes
    localparam logic [6:0] CHAR_CR  = 7'd13;
    localparam logic [6:0] CHAR_LF  = 7'd10;
    localparam logic [6:0] CHAR_PAD = 7'd61;
    localparam logic [6:0] CHAR_A   = 7'd65;
    localparam logic [6:0] CHAR_LA  = 7'd97;
    localparam logic [6:0] CHAR_D0  = 7'd48;
    localparam logic [6:0] CHAR_PLS = 7'd43;
    localparam logic [6:0] CHAR_SLH = 7'd47;

    // One group handed from the front to the back
    typedef struct packed {
        logic [23:0] bits;     // bytes left-aligned, oldest at the top
        logic [1:0]  count;    // number of real bytes, 1..3
        logic        is_last;  // group closes the message
        logic        brk;      // CR LF goes out before the group
    } grp_t;

    // Map a sextet onto the standard alphabet
    function automatic logic [6:0] sextet_char(input logic [5:0] v);
        logic [6:0] ch;
        if (v < 6'd26)
            ch = CHAR_A + {1'b0, v};
        else if (v < 6'd52)
            ch = CHAR_LA + {1'b0, v - 6'd26};
        else if (v < 6'd62)
            ch = CHAR_D0 + {1'b0, v - 6'd52};
        else if (v == 6'd62)
            ch = CHAR_PLS;
        else
            ch = CHAR_SLH;
        return ch;
    endfunction

endpackage

FILE: rtl/base64_line_wrapped_encoder_top.sv
// ----------------------------------------------------------------------------
// base64_line_wrapped_encoder_top
// Base64 encoder with CR LF line breaks every LINE_CHARS characters.
//
//   channel | direction | handshake          | beat
//   --------+-----------+--------------------+---------------------------
//   input   | in        | push / full        | data_byte, last_byte
//   result  | out       | empty / pop        | out_char, last_char
//
// A byte is taken every cycle while the group queue has room; a group of
// three bytes leaves as four characters, or six with a line break, one
// character a cycle from the back serialiser unless the output stalls,
// so that output sets the sustained rate.
// The first character of a group passes the group queue and then the
// output register before it reaches the result ports.
// Reset is asynchronous, active low; no clearing pass is needed.
// A stalled output stalls the serialiser, then the queue, then raises full.
// ----------------------------------------------------------------------------
module base64_line_wrapped_encoder_top #(
    parameter int LINE_CHARS = lwe_pkg::LINE_CHARS_DEF
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       push,
    output logic       full,
    input  logic [7:0] data_byte,
    input  logic       last_byte,
    input  logic       pop,
    output logic       empty,
    output logic [6:0] out_char,
    output logic       last_char
);
    import lwe_pkg::*;

    grp_t f_data;
    grp_t b_data;
    logic f_push;
    logic q_full;
    logic q_empty;
    logic q_pop;

    // Front: pack bytes and decide breaks
    lwe_front #(
        .LINE_CHARS (LINE_CHARS)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .full      (full),
        .data_byte (data_byte),
        .last_byte (last_byte),
        .q_full    (q_full),
        .q_push    (f_push),
        .q_data    (f_data)
    );

    // Group queue
    lwe_queue u_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (f_push),
        .din   (f_data),
        .full  (q_full),
        .pop   (q_pop),
        .dout  (b_data),
        .empty (q_empty)
    );

    // Back: serialise characters
    lwe_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_data    (b_data),
        .q_empty   (q_empty),
        .q_pop     (q_pop),
        .empty     (empty),
        .pop       (pop),
        .out_char  (out_char),
        .last_char (last_char)
    );

endmodule

FILE: rtl/lwe_front.sv
// ----------------------------------------------------------------------------
// lwe_front
// Collects bytes into groups of three, tracks the position in the line and
// hands each finished group, with its break decision, to the group queue.
// ----------------------------------------------------------------------------
module lwe_front #(
    parameter int LINE_CHARS = lwe_pkg::LINE_CHARS_DEF
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push,
    output logic          full,
    input  logic [7:0]    data_byte,
    input  logic          last_byte,
    input  logic          q_full,
    output logic          q_push,
    output lwe_pkg::grp_t q_data
);
    import lwe_pkg::*;

    localparam int MW = (LINE_CHARS > 1) ? $clog2(LINE_CHARS) : 1;
    localparam int SW = MW + 3;

    logic [15:0]   pend_reg, pend_next;
    logic [1:0]    count_reg, count_next;
    logic [MW-1:0] pos_reg, pos_next;       // (characters in line) mod LINE_CHARS
    logic          started_reg, started_next; // a group went out since the last break
    logic          accept;
    logic          grp_done;
    logic [23:0]   bits;
    logic [SW-1:0] pos_sum;

    assign full   = q_full;
    assign accept = push && !q_full;

    // Left-align buffered bytes and the new one
    always_comb
    begin
        case (count_reg)
            2'd0:    bits = {data_byte, 16'h0000};
            2'd1:    bits = {pend_reg[7:0], data_byte, 8'h00};
            default: bits = {pend_reg, data_byte};
        endcase
    end

    assign grp_done = (count_reg == 2'd2) || last_byte;

    // Advance the line position by one group
    always_comb
    begin
        pos_sum = {3'b000, pos_reg} + SW'(4);
        if (pos_sum >= SW'(LINE_CHARS))
            pos_sum = pos_sum - SW'(LINE_CHARS);
    end

    // Build the group and the next state
    always_comb
    begin
        pend_next      = pend_reg;
        count_next     = count_reg;
        pos_next       = pos_reg;
        started_next   = started_reg;
        q_push         = 1'b0;
        q_data.bits    = bits;
        q_data.count   = count_reg + 2'd1;
        q_data.is_last = last_byte;
        q_data.brk     = started_reg && (pos_reg == '0);
        if (accept)
        begin
            if (grp_done)
            begin
                q_push     = 1'b1;
                pend_next  = 16'h0000;
                count_next = 2'd0;
                if (last_byte)
                begin
                    pos_next     = '0;
                    started_next = 1'b0;
                end
                else
                begin
                    pos_next     = pos_sum[MW-1:0];
                    started_next = 1'b1;
                end
            end
            else
            begin
                pend_next  = {pend_reg[7:0], data_byte};
                count_next = count_reg + 2'd1;
            end
        end
    end

    // Hold the front state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend_reg    <= 16'h0000;
            count_reg   <= 2'd0;
            pos_reg     <= '0;
            started_reg <= 1'b0;
        end
        else
        begin
            pend_reg    <= pend_next;
            count_reg   <= count_next;
            pos_reg     <= pos_next;
            started_reg <= started_next;
        end
    end

endmodule

FILE: rtl/lwe_queue.sv
// ----------------------------------------------------------------------------
// lwe_queue
// Two-entry group queue between the front and the back.
// ----------------------------------------------------------------------------
module lwe_queue (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push,
    input  lwe_pkg::grp_t din,
    output logic          full,
    input  logic          pop,
    output lwe_pkg::grp_t dout,
    output logic          empty
);
    import lwe_pkg::*;

    grp_t       head_reg, head_next;
    grp_t       tail_reg, tail_next;
    logic [1:0] cnt_reg, cnt_next;
    logic       do_push;
    logic       do_pop;
    logic [1:0] cnt_left;

    assign full    = (cnt_reg == 2'd2);
    assign empty   = (cnt_reg == 2'd0);
    assign dout    = head_reg;
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;

    // Shift on pop, then place the new beat behind what is left
    always_comb
    begin
        head_next = head_reg;
        tail_next = tail_reg;
        cnt_left  = cnt_reg - {1'b0, do_pop};
        if (do_pop)
            head_next = tail_reg;
        if (do_push)
        begin
            if (cnt_left == 2'd0)
                head_next = din;
            else
                tail_next = din;
        end
        cnt_next = cnt_left + {1'b0, do_push};
    end

    // Hold the count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            cnt_reg <= 2'd0;
        else
            cnt_reg <= cnt_next;
    end

    // Hold the payload
    always_ff @(posedge clk)
    begin
        head_reg <= head_next;
        tail_reg <= tail_next;
    end

endmodule

FILE: rtl/lwe_back.sv
// ----------------------------------------------------------------------------
// lwe_back
// Serialises each group into an optional CR LF and four characters, one
// character a cycle unless the output stalls, into the output register.
// ----------------------------------------------------------------------------
module lwe_back (
    input  logic          clk,
    input  logic          rst_n,
    input  lwe_pkg::grp_t q_data,
    input  logic          q_empty,
    output logic          q_pop,
    output logic          empty,
    input  logic          pop,
    output logic [6:0]    out_char,
    output logic          last_char
);
    import lwe_pkg::*;

    typedef enum logic [5:0] {
        ST_HEAD = 6'b000001,
        ST_LF   = 6'b000010,
        ST_C0   = 6'b000100,
        ST_C1   = 6'b001000,
        ST_C2   = 6'b010000,
        ST_C3   = 6'b100000
    } st_t;

    st_t        state_reg, state_next;
    logic [6:0] char_reg, char_next;
    logic       lastc_reg, lastc_next;
    logic       ovalid_reg, ovalid_next;
    logic       emit;
    logic [1:0] k;
    logic       is_ctl;
    logic [6:0] ctl_char;
    logic [5:0] sextet;
    logic [6:0] data_char;

    assign empty     = !ovalid_reg;
    assign out_char  = char_reg;
    assign last_char = lastc_reg;

    // Emit when a group waits and the output register is free or being taken
    assign emit = !q_empty && (!ovalid_reg || pop);

    // Pick the slot and the next state
    always_comb
    begin
        k          = 2'd0;
        is_ctl     = 1'b0;
        ctl_char   = CHAR_CR;
        state_next = state_reg;
        case (state_reg)
            ST_HEAD:
            begin
                if (q_data.brk)
                begin
                    is_ctl     = 1'b1;
                    state_next = ST_LF;
                end
                else
                begin
                    k          = 2'd0;
                    state_next = ST_C1;
                end
            end
            ST_LF:
            begin
                is_ctl     = 1'b1;
                ctl_char   = CHAR_LF;
                state_next = ST_C0;
            end
            ST_C0:
            begin
                k          = 2'd0;
                state_next = ST_C1;
            end
            ST_C1:
            begin
                k          = 2'd1;
                state_next = ST_C2;
            end
            ST_C2:
            begin
                k          = 2'd2;
                state_next = ST_C3;
            end
            ST_C3:
            begin
                k          = 2'd3;
                state_next = ST_HEAD;
            end
            default:
            begin
                state_next = ST_HEAD;
            end
        endcase
    end

    // Select the sextet for the slot
    always_comb
    begin
        case (k)
            2'd0:    sextet = q_data.bits[23:18];
            2'd1:    sextet = q_data.bits[17:12];
            2'd2:    sextet = q_data.bits[11:6];
            default: sextet = q_data.bits[5:0];
        endcase
    end

    // Pad slots beyond the real bytes
    assign data_char = (k <= q_data.count) ? sextet_char(sextet) : CHAR_PAD;

    // Load the output register
    always_comb
    begin
        char_next   = char_reg;
        lastc_next  = lastc_reg;
        ovalid_next = ovalid_reg;
        q_pop       = 1'b0;
        if (emit)
        begin
            ovalid_next = 1'b1;
            char_next   = is_ctl ? ctl_char : data_char;
            lastc_next  = !is_ctl && q_data.is_last && (k == 2'd3);
            q_pop       = (state_reg == ST_C3);
        end
        else if (pop)
        begin
            ovalid_next = 1'b0;
        end
    end

    // Hold the control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_HEAD;
            ovalid_reg <= 1'b0;
        end
        else
        begin
            if (emit)
                state_reg <= state_next;
            ovalid_reg <= ovalid_next;
        end
    end

    // Hold the output payload
    always_ff @(posedge clk)
    begin
        char_reg  <= char_next;
        lastc_reg <= lastc_next;
    end

endmodule

FILE: rtl/lwe_checker.sv
// ----------------------------------------------------------------------------
// lwe_checker
// Port-level checks on the encoder's character stream, bound to the top.
// ----------------------------------------------------------------------------
module lwe_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       push,
    input logic       full,
    input logic       pop,
    input logic       empty,
    input logic [6:0] out_char,
    input logic       last_char
);
    import lwe_pkg::*;

    logic prev_cr_reg;
    logic prev_lf_reg;
    logic prev_last_reg;
    logic in_seen_reg;

    // Remember what the last taken beat was
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prev_cr_reg   <= 1'b0;
            prev_lf_reg   <= 1'b0;
            prev_last_reg <= 1'b0;
            in_seen_reg   <= 1'b0;
        end
        else
        begin
            if (pop && !empty)
            begin
                prev_cr_reg   <= (out_char == CHAR_CR);
                prev_lf_reg   <= (out_char == CHAR_LF);
                prev_last_reg <= last_char;
            end
            if (push && !full)
                in_seen_reg <= 1'b1;
        end
    end

    // A stalled result holds
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && !pop) |=> (!empty && $stable(out_char) && $stable(last_char)))
        else $error("result changed while stalled");

    // CR is always followed by LF
    a_crlf: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && prev_cr_reg) |-> (out_char == CHAR_LF))
        else $error("CR not followed by LF");

    // A line never starts with a control or pad character
    a_after_lf: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && prev_lf_reg) |->
            (out_char != CHAR_CR && out_char != CHAR_LF && out_char != CHAR_PAD))
        else $error("bad character after line break");

    // A new message, or a result before any byte was taken, opens without a break
    a_msg_start: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && (prev_last_reg || !in_seen_reg)) |-> (out_char != CHAR_CR))
        else $error("message opened with a line break");

    // The final mark never sits on a control character
    a_last: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && last_char) |-> (out_char != CHAR_CR && out_char != CHAR_LF))
        else $error("final mark on CR or LF");

endmodule

bind base64_line_wrapped_encoder_top lwe_checker u_lwe_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .full      (full),
    .pop       (pop),
    .empty     (empty),
    .out_char  (out_char),
    .last_char (last_char)
);
